### src/spherical_range_image_projector_macros.svh
// ----------------------------------------------------------------------------
// spherical range image projector assertion macros
// concurrent assertion helpers for the projector pipeline
// ----------------------------------------------------------------------------
`ifndef SPHERICAL_RANGE_IMAGE_PROJECTOR_MACROS_SVH
`define SPHERICAL_RANGE_IMAGE_PROJECTOR_MACROS_SVH
`ifndef ASSERT_OFF
`define SRIP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRIP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SRIP_ASSERT(label, clk, rst_n, prop, msg)
`define SRIP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

### src/srip_pkg.sv
// ----------------------------------------------------------------------------
// srip_pkg
// shared constants and types of the spherical range image projector
// ----------------------------------------------------------------------------
`default_nettype none
package srip_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int MAX_IMAGE_DIM = 4096;
    localparam int ROOT_STEPS    = 21;
    // cordic datapath: coordinates times 256, growth room for gain and sums
    localparam int CW  = 35;
    localparam int AW  = 26;
    localparam int SQW = 42;

    localparam logic [2:0] REG_AZ_CPD  = 3'd0;
    localparam logic [2:0] REG_EL_CPD  = 3'd1;
    localparam logic [2:0] REG_AZ_OFS  = 3'd2;
    localparam logic [2:0] REG_EL_OFS  = 3'd3;
    localparam logic [2:0] REG_COLUMNS = 3'd4;
    localparam logic [2:0] REG_ROWS    = 3'd5;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] acc;
    } cordic_t;

    function automatic logic signed [AW-1:0] atan_entry(input int i);
        logic signed [AW-1:0] v;
        case (i)
            0: v = 26'sd2949120;  1: v = 26'sd1740967;  2: v = 26'sd919879;
            3: v = 26'sd466945;   4: v = 26'sd234379;   5: v = 26'sd117304;
            6: v = 26'sd58666;    7: v = 26'sd29335;    8: v = 26'sd14668;
            9: v = 26'sd7334;     10: v = 26'sd3667;    11: v = 26'sd1833;
            12: v = 26'sd917;     13: v = 26'sd458;     14: v = 26'sd229;
            15: v = 26'sd115;     16: v = 26'sd57;      17: v = 26'sd29;
            18: v = 26'sd14;      19: v = 26'sd7;       20: v = 26'sd4;
            21: v = 26'sd2;       22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic cordic_t cordic_step(input cordic_t s, input int i);
        cordic_t r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        dx = s.y >>> i;
        dy = s.x >>> i;
        if (!s.y[CW-1])
        begin
            r.x = s.x + dx; r.y = s.y - dy; r.acc = s.acc + atan_entry(i);
        end
        else
        begin
            r.x = s.x - dx; r.y = s.y + dy; r.acc = s.acc - atan_entry(i);
        end
        return r;
    endfunction
endpackage
`default_nettype wire

### src/srip_cell_map.sv
// ----------------------------------------------------------------------------
// srip_cell_map
// three stage angle to cell index: offset removal, scale, clamp
// ----------------------------------------------------------------------------
`default_nettype none
module srip_cell_map (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [srip_pkg::AW-1:0] angle,
    input  wire logic signed [16:0]            offset,
    input  wire logic [23:0]                   cpd,
    input  wire logic [12:0]                   count,
    output logic [11:0]                        index
);
    import srip_pkg::*;

    logic signed [AW+1:0] diff_reg;
    logic signed [AW+26:0] prod_reg;
    logic [12:0] lim_reg;
    logic [12:0] lim2_reg;
    logic [12:0] n;
    logic [20:0] idx_raw;

    always_comb
    begin
        n = count;
        if (n == '0)
            n = 13'd1;
        if (n > 13'(MAX_IMAGE_DIM))
            n = 13'(MAX_IMAGE_DIM);
        idx_raw = prod_reg[AW+26] ? '0 :
                  (prod_reg == '0 ? '0 : 21'(prod_reg[AW+26:32]));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= (AW+2)'(angle) - ((AW+2)'(offset) <<< 8);
            lim_reg  <= n - 13'd1;
            prod_reg <= (AW+27)'(diff_reg) * $signed({1'b0, cpd});
            lim2_reg <= lim_reg;
            index    <= (idx_raw > 21'(lim2_reg)) ? lim2_reg[11:0] : idx_raw[11:0];
        end
    end
endmodule
`default_nettype wire

### src/spherical_range_image_projector.sv
// ----------------------------------------------------------------------------
// spherical range image projector
// projects lidar points onto range image pixels, one point per clock
// ----------------------------------------------------------------------------
// one point is taken per clock while the pipeline advances. its pixel write passes
// an input stage and a 21 stage restoring square root for the horizontal
// distance with the 16 stage azimuth cordic beside it, a second input stage
// and a 21 stage root for the range with the elevation cordic beside it,
// then three cell map stages. the pipeline is a single enable shift: it
// advances when the output register is free or taken, so a stall holds
// every stage and loses nothing.
`default_nettype none
module spherical_range_image_projector (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // x_mm[19:0], y_mm[39:20], z_mm[59:40]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // pixel_row, pixel_column, range_mm, range_saturated
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    import srip_pkg::*;
`include "spherical_range_image_projector_macros.svh"

    localparam int R1 = ROOT_STEPS;                 // dist root stages
    localparam int CS = CORDIC_STAGES + 1;          // pre-rotate plus stages
    localparam int R2 = ROOT_STEPS;                 // range root stages
    localparam int DEPTH = R1 + R2 + 2;             // before cell map

    // configuration registers
    logic [23:0]        az_cpd_reg, el_cpd_reg;
    logic signed [16:0] az_ofs_reg;
    logic signed [15:0] el_ofs_reg;
    logic [12:0]        cols_reg, rows_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            az_cpd_reg <= 24'd65536;
            el_cpd_reg <= 24'd65536;
            az_ofs_reg <= -17'sd46080;
            el_ofs_reg <= -16'sd5120;
            cols_reg   <= 13'd360;
            rows_reg   <= 13'd32;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_AZ_CPD:  az_cpd_reg <= cfg_data;
                REG_EL_CPD:  el_cpd_reg <= cfg_data;
                REG_AZ_OFS:  az_ofs_reg <= cfg_data[16:0];
                REG_EL_OFS:  el_ofs_reg <= cfg_data[15:0];
                REG_COLUMNS: cols_reg   <= cfg_data[12:0];
                REG_ROWS:    rows_reg   <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // global advance: output register empty or being drained
    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // valid shift line over the whole latency
    localparam int LAT = DEPTH + 3;
    logic [LAT-1:0] vld_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end
    assign m_axis_tvalid = vld_reg[LAT-1];

    logic signed [19:0] x_in, y_in, z_in;
    assign x_in = s_axis_tdata[19:0];
    assign y_in = s_axis_tdata[39:20];
    assign z_in = s_axis_tdata[59:40];

    // ---------------- first root (horizontal distance) with azimuth cordic ----------
    // root stage k: rem, root, bit = 4^(20-k)
    logic [SQW-1:0] r1_rem_reg  [R1+1];
    logic [SQW-1:0] r1_root_reg [R1+1];
    logic [SQW-1:0] h2_reg      [R1+1];
    logic [SQW-1:0] z2_reg      [R1+1];
    logic signed [19:0] zr_reg  [R1+1];
    cordic_t        az_reg      [R1+1];
    logic           az_zero_reg [R1+1];

    logic [SQW-1:0] h2_in, z2_in;
    cordic_t az_pre;
    always_comb
    begin
        h2_in = SQW'(unsigned'(40'(x_in * x_in))) + SQW'(unsigned'(40'(y_in * y_in)));
        z2_in = SQW'(unsigned'(40'(z_in * z_in)));
        az_pre.x = CW'(x_in) <<< 8;
        az_pre.y = CW'(y_in) <<< 8;
        az_pre.acc = '0;
        if (x_in[19])
        begin
            if (!y_in[19])
            begin
                az_pre.x = CW'(y_in) <<< 8; az_pre.y = -(CW'(x_in) <<< 8);
                az_pre.acc = AW'(90 * 65536);
            end
            else
            begin
                az_pre.x = -(CW'(y_in) <<< 8); az_pre.y = CW'(x_in) <<< 8;
                az_pre.acc = -AW'(90 * 65536);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_rem_reg[0]  <= h2_in;
            r1_root_reg[0] <= '0;
            h2_reg[0]      <= h2_in;
            z2_reg[0]      <= z2_in;
            zr_reg[0]      <= z_in;
            az_reg[0]      <= az_pre;
            az_zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar k = 0; k < R1; k++)
    begin : g_r1
        logic [SQW-1:0] bitv, trial;
        assign bitv  = SQW'(1) << (2 * (R1 - 1 - k));
        assign trial = r1_root_reg[k] + bitv;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (r1_rem_reg[k] >= trial)
                begin
                    r1_rem_reg[k+1]  <= r1_rem_reg[k] - trial;
                    r1_root_reg[k+1] <= (r1_root_reg[k] >> 1) + bitv;
                end
                else
                begin
                    r1_rem_reg[k+1]  <= r1_rem_reg[k];
                    r1_root_reg[k+1] <= r1_root_reg[k] >> 1;
                end
                h2_reg[k+1]      <= h2_reg[k];
                z2_reg[k+1]      <= z2_reg[k];
                zr_reg[k+1]      <= zr_reg[k];
                az_reg[k+1]      <= (k < CORDIC_STAGES) ? cordic_step(az_reg[k], k) : az_reg[k];
                az_zero_reg[k+1] <= az_zero_reg[k];
            end
        end
    end

    // ---------------- second root (range) with elevation cordic ----------
    logic [SQW-1:0] r2_rem_reg  [R2+1];
    logic [SQW-1:0] r2_root_reg [R2+1];
    cordic_t        el_reg      [R2+1];
    logic           el_zero_reg [R2+1];
    logic signed [AW-1:0] azr_reg [R2+1];

    cordic_t el_pre;
    logic [SQW-1:0] horiz_dist;
    always_comb
    begin
        horiz_dist = r1_root_reg[R1];
        el_pre.x = CW'(horiz_dist) <<< 8;
        el_pre.y = CW'(zr_reg[R1]) <<< 8;
        el_pre.acc = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_rem_reg[0]  <= h2_reg[R1] + z2_reg[R1];
            r2_root_reg[0] <= '0;
            el_reg[0]      <= el_pre;
            el_zero_reg[0] <= (horiz_dist == '0) && (zr_reg[R1] == '0);
            azr_reg[0]     <= az_zero_reg[R1] ? '0 : az_reg[R1].acc;
        end
    end

    for (genvar k = 0; k < R2; k++)
    begin : g_r2
        logic [SQW-1:0] bitv, trial;
        assign bitv  = SQW'(1) << (2 * (R2 - 1 - k));
        assign trial = r2_root_reg[k] + bitv;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (r2_rem_reg[k] >= trial)
                begin
                    r2_rem_reg[k+1]  <= r2_rem_reg[k] - trial;
                    r2_root_reg[k+1] <= (r2_root_reg[k] >> 1) + bitv;
                end
                else
                begin
                    r2_rem_reg[k+1]  <= r2_rem_reg[k];
                    r2_root_reg[k+1] <= r2_root_reg[k] >> 1;
                end
                el_reg[k+1]      <= (k < CORDIC_STAGES) ? cordic_step(el_reg[k], k) : el_reg[k];
                el_zero_reg[k+1] <= el_zero_reg[k];
                azr_reg[k+1]     <= azr_reg[k];
            end
        end
    end

    // range saturation, then align with the cell map
    logic [15:0] rng_reg [3];
    logic        sat_reg [3];
    logic signed [AW-1:0] el_ang;
    assign el_ang = el_zero_reg[R2] ? '0 : el_reg[R2].acc;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_reg[0] <= r2_root_reg[R2] > SQW'(65535);
            rng_reg[0] <= (r2_root_reg[R2] > SQW'(65535)) ? 16'hFFFF : r2_root_reg[R2][15:0];
            for (int i = 1; i < 3; i++)
            begin
                sat_reg[i] <= sat_reg[i-1];
                rng_reg[i] <= rng_reg[i-1];
            end
        end
    end

    logic [11:0] col_idx, row_idx;
    srip_cell_map u_col (
        .clk    (clk),
        .en     (en),
        .angle  (azr_reg[R2]),
        .offset (az_ofs_reg),
        .cpd    (az_cpd_reg),
        .count  (cols_reg),
        .index  (col_idx)
    );
    srip_cell_map u_row (
        .clk    (clk),
        .en     (en),
        .angle  (el_ang),
        .offset (17'(el_ofs_reg)),
        .cpd    (el_cpd_reg),
        .count  (rows_reg),
        .index  (row_idx)
    );

    assign m_axis_tdata = {7'd0, sat_reg[2], rng_reg[2], col_idx, row_idx};

    `SRIP_ASSERT(a_ready_follows_out, clk, rst_n, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready mismatch")
    `SRIP_ASSERT(a_hold_on_stall, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> $stable(vld_reg), "pipeline moved on stall")
    `SRIP_ASSERT(a_sat_range, clk, rst_n, (m_axis_tvalid && m_axis_tdata[40]) |-> (m_axis_tdata[39:24] == 16'hFFFF), "saturated range not max")
endmodule
`default_nettype wire

### tb/spherical_range_image_projector_tb.sv
// ----------------------------------------------------------------------------
// spherical range image projector testbench
// streams lidar points through the projector under several register settings
// and checks every pixel write against a built-in predictor of the block
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module spherical_range_image_projector_tb;
    import srip_pkg::*;

    localparam int  DRAIN_CYCLES   = 60;     // longer than the pipeline depth
    localparam int  WATCHDOG_LIMIT = 20000;  // cycles with no transfer at all
    localparam int  LONG_HOLD      = 300;    // long receiver hold-off
    localparam logic [2:0] REG_NONE_A = 3'd6;
    localparam logic [2:0] REG_NONE_B = 3'd7;

    // arctangent of 2^-i in degrees * 2^16
    localparam longint ATAN_DEG [0:15] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef struct packed {
        logic signed [19:0] z;
        logic signed [19:0] y;
        logic signed [19:0] x;
    } point_t;

    typedef struct {
        logic [11:0] row;
        logic [11:0] column;
        logic [15:0] range;
        logic        saturated;
    } pixel_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata  = '0;     // x_mm[19:0], y_mm[39:20], z_mm[59:40]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;           // row[11:0], column[23:12], range[39:24], sat[40]
    logic        cfg_we        = 1'b0;
    logic [2:0]  cfg_index     = '0;
    logic [23:0] cfg_data      = '0;

    // predictor copy of the registers
    logic [23:0] az_cpd;
    logic [23:0] el_cpd;
    logic [16:0] az_ofs;
    logic [15:0] el_ofs;
    logic [12:0] columns;
    logic [12:0] rows;

    point_t pending_points[$];
    pixel_t expected_pixels[$];
    point_t cur_point;
    bit     cur_taken   = 1'b0;
    int     send_gap    = 0;
    int     recv_stall  = 0;
    bit     hold_req    = 1'b0;
    int     idle_cycles = 0;
    int     errors      = 0;

    spherical_range_image_projector u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // floor of the square root, bit by bit
    function automatic longint floor_sqrt(input longint v);
        longint rem;
        longint root;
        longint b;
        rem  = v;
        root = 0;
        b    = longint'(1) << 40;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    // vectoring cordic, angle in degrees * 2^16
    function automatic longint angle_of(input longint yv, input longint xv);
        longint cx;
        longint cy;
        longint acc;
        longint sx;
        longint sy;
        cx  = xv * 256;
        cy  = yv * 256;
        acc = 0;
        if (xv == 0 && yv == 0)
            return 0;
        // left half plane: turn by a quarter first
        if (cx < 0)
        begin
            if (cy >= 0)
            begin
                cx  = cy;
                cy  = -xv * 256;
                acc = 90 * 65536;
            end
            else
            begin
                cx  = -cy;
                cy  = xv * 256;
                acc = -90 * 65536;
            end
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            sx = cy >>> i;
            sy = cx >>> i;
            if (cy >= 0)
            begin
                cx  = cx + sx;
                cy  = cy - sy;
                acc = acc + ATAN_DEG[i];
            end
            else
            begin
                cx  = cx - sx;
                cy  = cy + sy;
                acc = acc - ATAN_DEG[i];
            end
        end
        return acc;
    endfunction

    // angle to cell index, clamped into the image
    function automatic longint cell_of(input longint ang, input longint ofs,
                                       input longint cpd, input longint cnt);
        longint prod;
        longint n;
        longint idx;
        prod = (ang - ofs * 256) * cpd;
        n    = (cnt < 1) ? 1 : ((cnt > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : cnt);
        idx  = (prod > 0) ? (prod >>> 32) : 0;
        if (idx > n - 1)
            idx = n - 1;
        return idx;
    endfunction

    function automatic pixel_t project_point(input point_t p);
        pixel_t r;
        longint x;
        longint y;
        longint z;
        longint h2;
        longint horiz;
        longint rng;
        x     = p.x;
        y     = p.y;
        z     = p.z;
        h2    = x * x + y * y;
        horiz = floor_sqrt(h2);
        rng   = floor_sqrt(h2 + z * z);
        r.column = 12'(cell_of(angle_of(y, x), longint'($signed(az_ofs)),
                               longint'(az_cpd), longint'(columns)));
        r.row    = 12'(cell_of(angle_of(z, horiz), longint'($signed(el_ofs)),
                               longint'(el_cpd), longint'(rows)));
        r.saturated = rng > 65535;
        r.range     = r.saturated ? 16'hFFFF : rng[15:0];
        return r;
    endfunction

    // register write, only while the pipeline is empty
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_AZ_CPD:  az_cpd  = val;
            REG_EL_CPD:  el_cpd  = val;
            REG_AZ_OFS:  az_ofs  = val[16:0];
            REG_EL_OFS:  el_ofs  = val[15:0];
            REG_COLUMNS: columns = val[12:0];
            REG_ROWS:    rows    = val[12:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [23:0] acpd, input logic [23:0] ecpd,
                             input logic [23:0] aofs, input logic [23:0] eofs,
                             input logic [23:0] cols, input logic [23:0] rws);
        write_reg(REG_AZ_CPD, acpd);
        write_reg(REG_EL_CPD, ecpd);
        write_reg(REG_AZ_OFS, aofs);
        write_reg(REG_EL_OFS, eofs);
        write_reg(REG_COLUMNS, cols);
        write_reg(REG_ROWS, rws);
    endtask

    task automatic add_point(input int x, input int y, input int z);
        point_t p;
        p.x = 20'(x);
        p.y = 20'(y);
        p.z = 20'(z);
        pending_points.insert(pending_points.size(), p);
    endtask

    // mostly sensor-like points, some over the full field range
    task automatic add_random_points(input int count);
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 9))
                0, 1:    add_point($urandom, $urandom, $urandom);
                2:       add_point($urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20,
                                   $urandom_range(0, 40) - 20);
                default: add_point($urandom_range(0, 160000) - 80000,
                                   $urandom_range(0, 160000) - 80000,
                                   $urandom_range(0, 20000) - 10000);
            endcase
        end
    endtask

    // wait until every queued point has been sent and every pixel has come back
    task automatic drain;
        while (pending_points.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // input side: predict on every accepted transfer
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_pixels.insert(expected_pixels.size(), project_point(cur_point));
            cur_taken <= 1'b1;
        end
    end

    // driver: presents queued points with random gaps
    always @(negedge clk)
    begin
        logic   next_valid;
        point_t next_point;
        next_valid = s_axis_tvalid;
        next_point = cur_point;
        if (cur_taken)
        begin
            next_valid = 1'b0;
            cur_taken  <= 1'b0;
            send_gap   = ($urandom_range(0, 3) == 0) ? 0 :
                         (($urandom_range(0, 30) == 0) ? $urandom_range(10, 60)
                                                       : $urandom_range(0, 3));
        end
        if (!next_valid && rst_n)
        begin
            if (send_gap > 0)
                send_gap--;
            else if (pending_points.size() != 0)
            begin
                next_point = pending_points.pop_front();
                next_valid = 1'b1;
            end
        end
        cur_point     = next_point;
        s_axis_tvalid <= next_valid;
        s_axis_tdata  <= {4'b0, next_point.z, next_point.y, next_point.x};
    end

    // receiver backpressure, with one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req   <= 1'b0;
            recv_stall = LONG_HOLD;
        end
        if (recv_stall > 0)
        begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 40) == 0)
        begin
            recv_stall = $urandom_range(5, 50);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(0, 3) != 0);
    end

    // output side: compare against the oldest prediction
    always @(posedge clk)
    begin
        pixel_t exp_px;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $error("pixel write with no point outstanding: %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                exp_px = expected_pixels.pop_front();
                if (m_axis_tdata[11:0] !== exp_px.row)
                begin
                    $error("pixel_row expected %0d actual %0d", exp_px.row, m_axis_tdata[11:0]);
                    errors++;
                end
                if (m_axis_tdata[23:12] !== exp_px.column)
                begin
                    $error("pixel_column expected %0d actual %0d",
                           exp_px.column, m_axis_tdata[23:12]);
                    errors++;
                end
                if (m_axis_tdata[39:24] !== exp_px.range)
                begin
                    $error("range_mm expected %0d actual %0d", exp_px.range, m_axis_tdata[39:24]);
                    errors++;
                end
                if (m_axis_tdata[40] !== exp_px.saturated)
                begin
                    $error("range_saturated expected %0d actual %0d",
                           exp_px.saturated, m_axis_tdata[40]);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        // register copies start at their reset values
        az_cpd  = 24'd65536;
        el_cpd  = 24'd65536;
        az_ofs  = -17'sd46080;
        el_ofs  = -16'sd5120;
        columns = 13'd360;
        rows    = 13'd32;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed points under reset settings
        add_point(0, 0, 0);                       // zero vector
        add_point(1000, 0, 0);
        add_point(-1000, 0, 0);                   // azimuth of 180 degrees
        add_point(-1000, 5, 0);                   // left half, y positive
        add_point(-1000, -5, 0);                  // left half, y negative
        add_point(0, 1000, 0);
        add_point(0, -1000, 0);
        add_point(0, 0, 1000);                    // straight up
        add_point(0, 0, -1000);
        add_point(524287, 524287, 524287);        // far past range saturation
        add_point(-524288, -524288, -524288);
        add_point(-524288, 524287, 0);
        add_point(65535, 0, 0);                   // just below saturation
        add_point(65536, 0, 0);                   // just at saturation edge
        add_point(46340, 46341, 0);
        add_point(10000, 10000, 3000);
        add_point(10000, -10000, -3000);
        add_point(1, 1, 1);
        add_point(-1, -1, -1);
        add_point(5000, 0, 20000);                // elevation beyond rows
        add_point(5000, 0, -20000);               // elevation below offset
        drain();

        add_random_points(200);
        // first point waits behind a long receiver hold-off so the pipe fills up
        hold_req = 1'b1;
        drain();

        // extremes: largest scale, smallest offsets, biggest image
        write_all(24'hFFFFFF, 24'hFFFFFF, 24'(-46080), 24'(-23040), 24'd4096, 24'd4096);
        add_random_points(200);
        drain();

        // smallest scale, largest offsets, one pixel image
        write_all(24'd1, 24'd1, 24'd46080, 24'd23040, 24'd1, 24'd1);
        add_random_points(150);
        drain();

        // zero azimuth scale and column count, out of range row count and elevation offset
        write_all(24'd0, 24'd65536, 24'h1FFFF, 24'h8000, 24'd0, 24'd8191);
        write_reg(REG_NONE_A, 24'h123456);        // ignored index
        write_reg(REG_NONE_B, 24'hFFFFFF);
        add_random_points(150);
        drain();

        // a typical spinning sensor with fine cells
        write_all(24'd5 << 16, 24'd3 << 16, 24'(-46080), 24'(-6400), 24'd1800, 24'd64);
        add_random_points(250);
        drain();

        // random settings
        for (int ph = 0; ph < 3; ph++)
        begin
            write_all(24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 12)),
                      24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 12)),
                      24'($urandom), 24'($urandom),
                      24'($urandom_range(0, 8191)), 24'($urandom_range(0, 8191)));
            add_random_points(150);
            drain();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
+incdir+src
src/srip_pkg.sv
src/srip_cell_map.sv
src/spherical_range_image_projector.sv
tb/spherical_range_image_projector_tb.sv
